// ----- sv/chm_pkg.sv -----
// Package for the chained hash map: sizes, sequencer states and payload types.
// Used by chained_hash_map.sv and verif/tb.sv.
package chm_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int LINK_W      = SLOT_W + 1;
    // The bucket count never exceeds the maximum entry count, so one head per slot is enough.
    localparam int BKT_W       = SLOT_W;
    localparam int BUCKET_DEPTH = MAX_ENTRIES;
    localparam int LOG_W       = $clog2(SLOT_W + 1);
    localparam int CNT_W       = SLOT_W + 1;

    localparam logic [31:0] MIX_MUL_A = 32'h21f0aaad;
    localparam logic [31:0] MIX_MUL_B = 32'hd35a2d97;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_HEAD,
        ST_FIRST,
        ST_WALK,
        ST_CMP,
        ST_DECIDE,
        ST_RB_RD,
        ST_RB_KEY,
        ST_RB_LINK
    } chm_state_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] key;
        logic [31:0] value;
    } chm_req_t;

    typedef struct packed {
        logic              found;
        logic [31:0]       old_value;
        logic [SLOT_W-1:0] slot;
        logic              created;
        logic              full_res;
    } chm_rsp_t;

endpackage

// ----- sv/chm_if.sv -----
// Valid/ready channel interface carrying one payload item.
// Payload type is given as a type parameter; used with chm_pkg types.
interface chm_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/chained_hash_map.sv -----
// Top level of the chained hash map: sequencer, shared mix unit and entry memories.
// Depends on chm_pkg and chm_if.
//
// Usage: requests enter on req (sink), one result item per request leaves on rsp
// (source). A request is taken only while the block is idle; ready stays low from
// acceptance until its result has left the output register.
// From acceptance the key passes the three mix steps, the bucket head is read, then
// each chain entry is read and its key compared until a hit or the end of the chain,
// and the result is registered. The one shared 32x32 multiplier (first two mix steps) and
// the single read port of each entry memory make this walk sequential.
// A put of a new key when the entry count equals the bucket count (store not full)
// doubles the buckets first: a clearing sweep over every bucket, then each stored entry
// is read, rehashed and linked into its chain again, then the walk of the request repeats.
// Reset clears the sequencer, entry count, bucket count and output valid, then a
// clearing pass empties the single bucket before ready rises.
// If the receiver stalls, the result waits in the output register and no new
// request is taken until it is delivered.
module chained_hash_map (
    input  logic clk,
    input  logic rst_n,
    chm_if.sink   req,
    chm_if.source rsp
);
    import chm_pkg::*;

    chm_state_t state_reg, state_next;

    logic [31:0]       key_mem  [MAX_ENTRIES];
    logic [31:0]       val_mem  [MAX_ENTRIES];
    logic [LINK_W-1:0] nxt_mem  [MAX_ENTRIES];
    logic [LINK_W-1:0] head_mem [BUCKET_DEPTH];

    chm_req_t          rq_reg;
    logic [31:0]       x_reg;
    logic [31:0]       prod_reg;
    logic [LINK_W-1:0] link_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [LOG_W-1:0]  log_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [BKT_W-1:0]  clr_reg;
    logic              rb_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [31:0]       rkey_reg;
    logic [31:0]       rval_reg;
    logic [LINK_W-1:0] rnxt_reg;
    logic [LINK_W-1:0] hrd_reg;
    chm_rsp_t          out_reg;
    logic              out_vld_reg;

    chm_rsp_t          res_next;
    logic              grow;
    logic              create;
    logic              val_we;
    logic              key_we;
    logic              nxt_we;
    logic              head_we;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] val_wa;
    logic [SLOT_W-1:0] nxt_wa;
    logic [BKT_W-1:0]  head_wa;
    logic [LINK_W-1:0] head_wd;

    logic [31:0] mix_x, mix_y, mul_a, mul_b, mul_out;
    logic [CNT_W-1:0]  bkt_count;
    logic [BKT_W-1:0]  mask;
    logic [SLOT_W-1:0] cur_slot;
    logic [SLOT_W-1:0] new_slot;
    logic [SLOT_W-1:0] j_slot;
    logic hit;
    logic rb_last;

    // Shared mix unit: one multiplier, constant chosen by the mix step.
    assign mix_x     = x_reg ^ (x_reg >> 16);
    assign mix_y     = prod_reg ^ (prod_reg >> 15);
    assign mul_a     = (state_reg == ST_MIX1) ? mix_x : mix_y;
    assign mul_b     = (state_reg == ST_MIX1) ? MIX_MUL_A : MIX_MUL_B;
    assign mul_out   = mul_a * mul_b;
    assign bkt_count = CNT_W'(1) << log_reg;
    assign mask      = BKT_W'(bkt_count - CNT_W'(1));
    assign cur_slot  = SLOT_W'(link_reg - LINK_W'(1));
    assign new_slot  = count_reg[SLOT_W-1:0];
    assign j_slot    = j_reg[SLOT_W-1:0];
    assign hit       = (rkey_reg == rq_reg.key);
    assign rb_last   = ((j_reg + CNT_W'(1)) == count_reg);

    assign req.ready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:
            begin
                if (clr_reg == mask)
                    state_next = rb_reg ? ST_RB_RD : ST_IDLE;
            end
            ST_IDLE:    if (req.valid && req.ready) state_next = ST_MIX1;
            ST_MIX1:    state_next = ST_MIX2;
            ST_MIX2:    state_next = ST_MIX3;
            ST_MIX3:    state_next = ST_HEAD;
            ST_HEAD:    state_next = rb_reg ? ST_RB_LINK : ST_FIRST;
            ST_FIRST:   state_next = ST_WALK;
            ST_WALK:    state_next = (link_reg == '0) ? ST_DECIDE : ST_CMP;
            ST_CMP:     state_next = hit ? ST_DECIDE : ST_WALK;
            ST_DECIDE:  state_next = grow ? ST_CLR : ST_IDLE;
            ST_RB_RD:   state_next = ST_RB_KEY;
            ST_RB_KEY:  state_next = ST_MIX1;
            ST_RB_LINK: state_next = rb_last ? ST_MIX1 : ST_RB_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res_next = '0;
        grow     = 1'b0;
        if (link_reg != '0) begin
            res_next.found     = 1'b1;
            res_next.old_value = rval_reg;
            res_next.slot      = cur_slot;
        end else if (rq_reg.req_type == REQ_PUT) begin
            if (count_reg >= CNT_W'(MAX_ENTRIES)) begin
                res_next.full_res = 1'b1;
            end else begin
                grow             = (count_reg == bkt_count);
                res_next.created = 1'b1;
                res_next.slot    = new_slot;
            end
        end

        rd_addr = rb_reg ? j_slot : cur_slot;
        create  = (state_reg == ST_DECIDE) && res_next.created && !grow;
        val_we  = create || ((state_reg == ST_DECIDE) && res_next.found
                             && rq_reg.req_type == REQ_PUT);
        val_wa  = (link_reg != '0) ? cur_slot : new_slot;
        key_we  = create;
        nxt_we  = create || (state_reg == ST_RB_LINK);
        nxt_wa  = rb_reg ? j_slot : new_slot;
        head_we = create || (state_reg == ST_RB_LINK) || (state_reg == ST_CLR);
        head_wa = (state_reg == ST_CLR) ? clr_reg : bkt_reg;
        if (state_reg == ST_CLR)
            head_wd = '0;
        else if (rb_reg)
            head_wd = LINK_W'(j_reg) + LINK_W'(1);
        else
            head_wd = LINK_W'(count_reg) + LINK_W'(1);
    end

    // Entry memories and bucket heads: one write port each, registered read.
    always_ff @(posedge clk)
    begin
        rkey_reg <= key_mem[rd_addr];
        rval_reg <= val_mem[rd_addr];
        rnxt_reg <= nxt_mem[rd_addr];
        hrd_reg  <= head_mem[bkt_reg];
        if (val_we)
            val_mem[val_wa] <= rq_reg.value;
        if (key_we)
            key_mem[new_slot] <= rq_reg.key;
        if (nxt_we)
            nxt_mem[nxt_wa] <= hrd_reg;
        if (head_we)
            head_mem[head_wa] <= head_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_CLR;
            count_reg   <= '0;
            log_reg     <= '0;
            clr_reg     <= '0;
            rb_reg      <= 1'b0;
            j_reg       <= '0;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
            rq_reg      <= '0;
            x_reg       <= '0;
            prod_reg    <= '0;
            link_reg    <= '0;
            bkt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DECIDE && !grow)
                out_vld_reg <= 1'b1;
            else if (rsp.valid && rsp.ready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_CLR:     clr_reg <= clr_reg + BKT_W'(1);
                ST_IDLE:
                begin
                    if (req.valid && req.ready) begin
                        rq_reg <= req.data;
                        x_reg  <= req.data.key;
                    end
                end
                ST_MIX1, ST_MIX2: prod_reg <= mul_out;
                ST_MIX3:    bkt_reg  <= mix_y[BKT_W-1:0] & mask;
                ST_HEAD:    ;
                ST_FIRST:   link_reg <= hrd_reg;
                ST_WALK:    ;
                ST_CMP:     if (!hit) link_reg <= rnxt_reg;
                ST_DECIDE:
                begin
                    if (grow) begin
                        log_reg <= log_reg + LOG_W'(1);
                        clr_reg <= '0;
                        j_reg   <= '0;
                        rb_reg  <= 1'b1;
                    end else begin
                        out_reg <= res_next;
                        if (res_next.created)
                            count_reg <= count_reg + CNT_W'(1);
                    end
                end
                ST_RB_RD:   ;
                ST_RB_KEY:  x_reg <= rkey_reg;
                ST_RB_LINK:
                begin
                    j_reg <= j_reg + CNT_W'(1);
                    // After the last stored entry the request key is hashed again.
                    if (rb_last) begin
                        rb_reg <= 1'b0;
                        x_reg  <= rq_reg.key;
                    end
                end
                default:    ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == ST_MIX1)
        else $error("accepted request did not start the mix");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond maximum");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.created |-> !rsp.data.found && !rsp.data.full_res)
        else $error("created result also flagged found or full");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !req.ready)
        else $error("request taken while a result is pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("result item changed while stalled");

endmodule

// ----- verif/tb.sv -----
// Testbench for the chained hash map: directed table, random gets and puts, then a fill
// to the maximum, checked against a behavioral map kept in the bench. Depends on chm_pkg, chm_if.
`timescale 1ns / 100ps

module tb;
    import chm_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int CYCLE_LIMIT = 1500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    chm_if #(.payload_t(chm_req_t)) req ();
    chm_if #(.payload_t(chm_rsp_t)) rsp ();

    chained_hash_map DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Map state mirrored in the bench.
    logic [31:0] map_keys [MAX_ENTRIES];
    logic [31:0] map_vals [MAX_ENTRIES];
    int unsigned map_next [MAX_ENTRIES];
    int unsigned map_head [BUCKET_DEPTH];
    int unsigned map_count;
    int unsigned map_log;

    chm_rsp_t pending_rsp [$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    logic [31:0] used_keys [$];

    typedef struct {
        chm_req_t   rq;
        bit         typed;
        chm_rsp_t   rs;
    } dir_row_t;

    function automatic logic [31:0] mix_key(logic [31:0] x);
        x = x ^ (x >> 16);
        x = x * MIX_MUL_A;
        x = x ^ (x >> 15);
        x = x * MIX_MUL_B;
        x = x ^ (x >> 15);
        return x;
    endfunction

    function automatic int unsigned bucket_for(logic [31:0] k);
        return mix_key(k) & ((32'd1 << map_log) - 1);
    endfunction

    function automatic int unsigned lookup_link(logic [31:0] k);
        int unsigned lk;
        lk = map_head[bucket_for(k)];
        while (lk != 0) begin
            if (map_keys[lk - 1] == k)
                return lk;
            lk = map_next[lk - 1];
        end
        return 0;
    endfunction

    function automatic chm_rsp_t apply_request(chm_req_t rq);
        chm_rsp_t r;
        int unsigned lk;
        int unsigned b;
        r = '0;
        lk = lookup_link(rq.key);
        if (lk != 0) begin
            r.found = 1'b1;
            r.slot = SLOT_W'(lk - 1);
            r.old_value = map_vals[lk - 1];
            if (rq.req_type == REQ_PUT)
                map_vals[lk - 1] = rq.value;
        end else if (rq.req_type == REQ_PUT) begin
            if (map_count >= MAX_ENTRIES) begin
                r.full_res = 1'b1;
            end else begin
                if (map_count == (1 << map_log)) begin
                    // Bucket count doubles; every chain is rebuilt in slot order.
                    map_log++;
                    foreach (map_head[i]) map_head[i] = 0;
                    for (int j = 0; j < map_count; j++) begin
                        b = bucket_for(map_keys[j]);
                        map_next[j] = map_head[b];
                        map_head[b] = j + 1;
                    end
                end
                b = bucket_for(rq.key);
                r.slot = SLOT_W'(map_count);
                map_keys[map_count] = rq.key;
                map_vals[map_count] = rq.value;
                map_next[map_count] = map_head[b];
                map_head[b] = map_count + 1;
                map_count++;
                r.created = 1'b1;
                used_keys.push_back(rq.key);
            end
        end
        return r;
    endfunction

    // Within this task valid is only lowered in the idle loop, so each falling edge sees one drive.
    task automatic send_request(chm_req_t rq, bit typed, chm_rsp_t typed_rs);
        chm_rsp_t pr;
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data <= rq;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        pr = apply_request(rq);
        if (typed && pr != typed_rs) begin
            $display("%0t: table row disagrees with map: expected %p got %p",
                     $time, typed_rs, pr);
            errors++;
        end
        pending_rsp.push_back(pr);
        sent++;
        @(negedge clk);
    endtask

    function automatic chm_req_t random_request();
        chm_req_t rq;
        int unsigned pick;
        rq.req_type = $urandom_range(99) < 60 ? REQ_PUT : REQ_GET;
        rq.value = $urandom();
        pick = $urandom_range(99);
        if (used_keys.size() != 0 && pick < 55)
            rq.key = used_keys[$urandom_range(used_keys.size() - 1)];
        else if (pick < 65)
            rq.key = $urandom_range(15);
        else
            rq.key = $urandom();
        return rq;
    endfunction

    // Result checking at the rising edge.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result item %p", $time, rsp.data);
                errors++;
            end else begin
                chm_rsp_t ex;
                ex = pending_rsp.pop_front();
                if (rsp.data.found !== ex.found)
                    $display("%0t: found expected %0d got %0d", $time, ex.found,
                             rsp.data.found);
                if (rsp.data.old_value !== ex.old_value)
                    $display("%0t: old_value expected %h got %h", $time,
                             ex.old_value, rsp.data.old_value);
                if (rsp.data.slot !== ex.slot)
                    $display("%0t: slot expected %0d got %0d", $time, ex.slot,
                             rsp.data.slot);
                if (rsp.data.created !== ex.created)
                    $display("%0t: created expected %0d got %0d", $time,
                             ex.created, rsp.data.created);
                if (rsp.data.full_res !== ex.full_res)
                    $display("%0t: full_res expected %0d got %0d", $time,
                             ex.full_res, rsp.data.full_res);
                if (rsp.data !== ex)
                    errors++;
            end
        end
    end

    // Receiver ready, driven at the falling edge.
    always @(negedge clk) begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_off)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off while the sender keeps offering.
    initial begin
        wait (sent == 100);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        dir_row_t rows [$];
        dir_row_t row;
        chm_req_t rq;
        int unsigned phase;
        logic [31:0] probe;

        req.valid = 1'b0;
        req.data = '0;
        map_count = 0;
        map_log = 0;
        foreach (map_head[i]) map_head[i] = 0;

        // Rows with a typed result come straight from the map's rules.
        row = '{'{REQ_GET, 32'h0, 32'h0}, 1'b1, '0};
        rows.push_back(row);
        row = '{'{REQ_PUT, 32'h0, 32'hffffffff}, 1'b1,
                '{1'b0, 32'h0, SLOT_W'(0), 1'b1, 1'b0}};
        rows.push_back(row);
        row = '{'{REQ_GET, 32'h0, 32'h1234}, 1'b1,
                '{1'b1, 32'hffffffff, SLOT_W'(0), 1'b0, 1'b0}};
        rows.push_back(row);
        row = '{'{REQ_PUT, 32'hffffffff, 32'h0}, 1'b1,
                '{1'b0, 32'h0, SLOT_W'(1), 1'b1, 1'b0}};
        rows.push_back(row);
        row = '{'{REQ_PUT, 32'hffffffff, 32'h5a5a5a5a}, 1'b1,
                '{1'b1, 32'h0, SLOT_W'(1), 1'b0, 1'b0}};
        rows.push_back(row);
        row = '{'{REQ_GET, 32'h80000000, 32'h0}, 1'b1, '0};
        rows.push_back(row);
        for (int i = 0; i < 14; i++) begin
            row = '{'{i[0] ? REQ_GET : REQ_PUT, 32'h1 << i, ~(32'h1 << i)}, 1'b0, '0};
            rows.push_back(row);
        end
        row = '{'{REQ_GET, 32'hffffffff, 32'h0}, 1'b0, '0};
        rows.push_back(row);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_request(rows[i].rq, rows[i].typed, rows[i].rs);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            repeat (200) send_request(random_request(), 1'b0, '0);
        end

        // Fill the store to its maximum, then probe refusals and hits.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (map_count < MAX_ENTRIES) begin
            rq.req_type = REQ_PUT;
            rq.key = $urandom();
            rq.value = $urandom();
            send_request(rq, 1'b0, '0);
        end
        repeat (30) begin
            probe = $urandom();
            if (lookup_link(probe) == 0) begin
                rq = '{REQ_PUT, probe, $urandom()};
                send_request(rq, 1'b1, '{1'b0, 32'h0, SLOT_W'(0), 1'b0, 1'b1});
            end
            send_request(random_request(), 1'b0, '0);
        end
        req.valid <= 1'b0;

        while (pending_rsp.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/chm_pkg.sv
sv/chm_if.sv
sv/chained_hash_map.sv
verif/tb.sv
